// File: hdl/jsu_pkg.sv
// Shared types, character codes and a helper function of the JSON string unescaper.
`default_nettype none
package jsu_pkg;

    // Result kind carried in tuser
    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    // Decoder phase, one-hot
    typedef enum logic [6:0] {
        PH_WAIT = 7'b0000001,
        PH_STR  = 7'b0000010,
        PH_ESC  = 7'b0000100,
        PH_HEX1 = 7'b0001000,
        PH_HEX2 = 7'b0010000,
        PH_HEX3 = 7'b0100000,
        PH_HEX4 = 7'b1000000
    } t_phase;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [7:0] CTL_BS  = 8'h08;
    localparam logic [7:0] CTL_FF  = 8'h0C;
    localparam logic [7:0] CTL_LF  = 8'h0A;
    localparam logic [7:0] CTL_CR  = 8'h0D;
    localparam logic [7:0] CTL_TAB = 8'h09;

    localparam logic [7:0] UTF_CONT  = 8'h80;
    localparam logic [7:0] UTF_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF_LEAD3 = 8'hE0;

    // Up to three decoded results caused by one input byte
    typedef struct packed {
        logic [1:0] cnt;     // number of results, 0..3
        t_kind      kind;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
    } t_bundle;

    // Hex digit check: bit 4 is set for a valid digit, bits 3:0 hold its value
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] res;
        res = 5'd0;
        if (b inside {[8'h30:8'h39]}) begin
            res = {1'b1, b[3:0]};
        end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            res = {1'b1, b[3:0] + 4'd9};
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// File: hdl/jsu_decode.sv
// Per-byte decoder: phase and hex accumulator, and the result bundle for one byte.
`default_nettype none
module jsu_decode
    import jsu_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_eot,
    output t_bundle         o_bundle
);

    t_phase      r_phase, n_phase;
    logic [11:0] r_accum, n_accum;
    logic [4:0]  hex;
    logic [15:0] code;
    logic        err;

    assign hex  = hex_value(i_byte);
    assign code = {r_accum, hex[3:0]};

    always_comb begin
        n_phase  = r_phase;
        n_accum  = r_accum;
        err      = 1'b0;
        o_bundle = '{cnt: 2'd0, kind: KIND_DATA, byte0: 8'd0, byte1: 8'd0, byte2: 8'd0};
        case (r_phase)
            PH_STR: begin
                if (i_byte == CH_QUOTE) begin
                    n_phase        = PH_WAIT;
                    n_accum        = 12'd0;
                    o_bundle.cnt   = 2'd1;
                    o_bundle.kind  = KIND_DONE;
                end else if (i_eot) begin
                    err = 1'b1;
                end else if (i_byte == CH_BSLASH) begin
                    n_phase = PH_ESC;
                end else begin
                    o_bundle.cnt   = 2'd1;
                    o_bundle.byte0 = i_byte;
                end
            end
            PH_ESC: begin
                if (i_eot) begin
                    err = 1'b1;
                end else begin
                    n_phase      = PH_STR;
                    o_bundle.cnt = 2'd1;
                    case (i_byte)
                        CH_QUOTE:  o_bundle.byte0 = CH_QUOTE;
                        CH_BSLASH: o_bundle.byte0 = CH_BSLASH;
                        CH_SLASH:  o_bundle.byte0 = CH_SLASH;
                        CH_B:      o_bundle.byte0 = CTL_BS;
                        CH_F:      o_bundle.byte0 = CTL_FF;
                        CH_N:      o_bundle.byte0 = CTL_LF;
                        CH_R:      o_bundle.byte0 = CTL_CR;
                        CH_T:      o_bundle.byte0 = CTL_TAB;
                        CH_U: begin
                            n_phase      = PH_HEX1;
                            n_accum      = 12'd0;
                            o_bundle.cnt = 2'd0;
                        end
                        default:   err = 1'b1;
                    endcase
                end
            end
            PH_HEX1, PH_HEX2, PH_HEX3: begin
                if (i_eot || !hex[4]) begin
                    err = 1'b1;
                end else begin
                    n_accum = {r_accum[7:0], hex[3:0]};
                    case (r_phase)
                        PH_HEX1: n_phase = PH_HEX2;
                        PH_HEX2: n_phase = PH_HEX3;
                        default: n_phase = PH_HEX4;
                    endcase
                end
            end
            PH_HEX4: begin
                if (i_eot || !hex[4]) begin
                    err = 1'b1;
                end else begin
                    n_phase = PH_STR;
                    n_accum = 12'd0;
                    // Encode the code point as UTF-8
                    if (code[15:7] == 9'd0) begin
                        o_bundle.cnt   = 2'd1;
                        o_bundle.byte0 = {1'b0, code[6:0]};
                    end else if (code[15:11] == 5'd0) begin
                        o_bundle.cnt   = 2'd2;
                        o_bundle.byte0 = UTF_LEAD2 | {3'd0, code[10:6]};
                        o_bundle.byte1 = UTF_CONT | {2'd0, code[5:0]};
                    end else begin
                        o_bundle.cnt   = 2'd3;
                        o_bundle.byte0 = UTF_LEAD3 | {4'd0, code[15:12]};
                        o_bundle.byte1 = UTF_CONT | {2'd0, code[11:6]};
                        o_bundle.byte2 = UTF_CONT | {2'd0, code[5:0]};
                    end
                end
            end
            default: begin
                // Waiting for the opening quote
                if (i_byte != CH_QUOTE || i_eot) begin
                    err = 1'b1;
                end else begin
                    n_phase = PH_STR;
                end
            end
        endcase
        if (err) begin
            n_phase  = PH_WAIT;
            n_accum  = 12'd0;
            o_bundle = '{cnt: 2'd1, kind: KIND_ERR, byte0: 8'd0, byte1: 8'd0, byte2: 8'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT;
            r_accum <= 12'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_accum <= n_accum;
        end
    end

endmodule
`default_nettype wire

// File: hdl/jsu_out_buf.sv
// Result register: holds one bundle and drains it one result per transaction.
`default_nettype none
module jsu_out_buf
    import jsu_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire t_bundle    i_bundle,
    output logic            o_free,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_byte,
    output t_kind           o_kind,
    output logic            o_last
);

    logic       r_valid, n_valid;
    t_bundle    r_bundle;
    logic [1:0] r_idx, n_idx;
    logic       take;

    assign o_valid = r_valid;
    assign o_kind  = r_bundle.kind;
    assign o_last  = (r_idx == r_bundle.cnt - 2'd1);
    assign take    = r_valid && i_ready;
    assign o_free  = !r_valid || (i_ready && o_last);

    always_comb begin
        case (r_idx)
            2'd0:    o_byte = r_bundle.byte0;
            2'd1:    o_byte = r_bundle.byte1;
            default: o_byte = r_bundle.byte2;
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (take) begin
            if (o_last) begin
                n_valid = 1'b0;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
        if (i_accept && i_bundle.cnt != 2'd0) begin
            n_valid = 1'b1;
            n_idx   = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    // Payload: load only when a new bundle with results comes in
    always_ff @(posedge i_clk) begin
        if (i_accept && i_bundle.cnt != 2'd0) begin
            r_bundle <= i_bundle;
        end
    end

endmodule
`default_nettype wire

// File: hdl/json_string_unescape_core.sv
// Top level of the JSON string unescaper: stream ports, decoder and result register.
`default_nettype none
// Decodes one JSON string literal per run, one encoded byte per input transaction,
// opening quote first. Simple escapes give one byte, \uXXXX gives its UTF-8 form in
// one to three bytes (surrogates are passed as separate three-byte sequences), the
// closing quote gives a "complete" result and any framing or escape fault gives a
// single "error" result; either way the block then waits for the next opening quote.
// Output kind is on tuser (0 data, 1 complete, 2 error) and tlast marks the final
// result caused by an input byte. Each input byte is decoded in the cycle it is
// accepted and its results appear from the next cycle on. The input accepts one
// byte per cycle while the output is ready and every byte yields at most one result;
// a byte that yields two or three UTF-8 bytes holds the input until its last one is
// taken, since the result register drains one result per output transaction. Bytes
// that yield no result (opening quote, backslash, the first hex digits) pass freely.
module json_string_unescape_core
    import jsu_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  wire logic       i_s_axis_tlast,   // end_of_text
    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output logic [7:0]      o_m_axis_tdata,   // [7:0] out_byte
    output logic [1:0]      o_m_axis_tuser,   // [1:0] kind
    output logic            o_m_axis_tlast    // last_of_run
);

    logic    w_accept;
    logic    w_free;
    t_bundle w_bundle;
    t_kind   w_kind;

    // Accept a byte only when the result register is empty or drains this cycle
    assign o_s_axis_tready = w_free;
    assign w_accept        = i_s_axis_tvalid && w_free;
    assign o_m_axis_tuser  = w_kind;

    jsu_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (i_s_axis_tdata),
        .i_eot    (i_s_axis_tlast),
        .o_bundle (w_bundle)
    );

    jsu_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_bundle (w_bundle),
        .o_free   (w_free),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_byte   (o_m_axis_tdata),
        .o_kind   (w_kind),
        .o_last   (o_m_axis_tlast)
    );

`ifndef ASSERT_OFF
    // Completion and error are always a single result
    a_ctl_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != KIND_DATA |-> o_m_axis_tlast)
        else $error("complete or error result not marked last");

    // A multi-byte run keeps going after a non-final transaction
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast |=> o_m_axis_tvalid)
        else $error("result run dropped before its last byte");

    // Input stays stalled while results of the previous byte remain
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !(i_m_axis_tready && o_m_axis_tlast) |-> !o_s_axis_tready)
        else $error("input accepted while earlier results are pending");

    // Data bytes and zero payload agree with the kind
    a_ctl_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != KIND_DATA |-> o_m_axis_tdata == 8'd0)
        else $error("nonzero byte on complete or error result");
`endif

endmodule
`default_nettype wire

// File: tb/tb_json_string_unescape_core.sv
// Self-checking testbench for the JSON string unescaper stream core.
`timescale 1ns / 1ps
module tb_json_string_unescape_core
    import jsu_pkg::*;
();

    localparam int N_DIR       = 29;
    localparam int N_RAND      = 395;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 20;

    // One decoded result as it leaves the core
    typedef struct {
        logic [7:0] data;
        t_kind      kind;
        logic       last;
    } t_dec_result;

    // Directed row: input byte, end-of-text flag and, where obvious, the single result
    typedef struct {
        logic [7:0] data;
        logic       eot;
        logic       typed;
        logic [7:0] want_data;
        t_kind      want_kind;
    } t_dir_row;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tready = 1'b0;
    logic       hold_req = 1'b0;   // ask the receiver for one long hold-off
    logic       quiet    = 1'b0;   // no idling on either side while set

    wire        s_tready;
    wire        m_tvalid;
    wire [7:0]  m_tdata;
    wire [1:0]  m_tuser;
    wire        m_tlast;

    // Decoder state mirrored by the predictor
    t_phase      dec_phase = PH_WAIT;
    logic [11:0] dec_accum = 12'h000;
    t_dec_result step_out[$];
    t_dec_result due_results[$];

    int n_errors = 0;
    int n_in     = 0;
    int n_data   = 0;
    int n_done   = 0;
    int n_fault  = 0;
    int n_wide   = 0;
    int cycles   = 0;

    t_dir_row dir_rows [N_DIR];

    json_string_unescape_core u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic is_hex_digit(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46)
            || (b >= 8'h61 && b <= 8'h66);
    endfunction

    // Fold to lower case for letters; truncation to four bits keeps the value
    function automatic logic [3:0] hex_nibble(input logic [7:0] b);
        logic [7:0] v;
        v = (b <= 8'h39) ? b - 8'h30 : (b | 8'h20) - 8'h61 + 8'd10;
        return v[3:0];
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        if (nib < 4'd10) begin
            return 8'h30 + nib;
        end
        return (upper ? 8'h41 : 8'h61) + nib - 8'd10;
    endfunction

    function automatic void emit(input logic [7:0] data, input t_kind kind, input logic last);
        t_dec_result r;
        r.data = data;
        r.kind = kind;
        r.last = last;
        step_out.push_back(r);
    endfunction

    // Any fault: one error result, back to waiting for a quote
    function automatic void decode_fault();
        dec_phase = PH_WAIT;
        dec_accum = 12'h000;
        emit(8'h00, KIND_ERR, 1'b1);
    endfunction

    // Predict the results of one accepted byte into step_out and advance the state
    function automatic void decode_byte(input logic [7:0] b, input logic eot);
        logic [15:0] cp;
        step_out.delete();
        case (dec_phase)
            PH_STR: begin
                if (b == CH_QUOTE) begin
                    dec_phase = PH_WAIT;
                    dec_accum = 12'h000;
                    emit(8'h00, KIND_DONE, 1'b1);
                end else if (eot) begin
                    decode_fault();
                end else if (b == CH_BSLASH) begin
                    dec_phase = PH_ESC;
                end else begin
                    emit(b, KIND_DATA, 1'b1);
                end
            end
            PH_ESC: begin
                if (eot) begin
                    decode_fault();
                end else begin
                    dec_phase = PH_STR;
                    case (b)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: emit(b, KIND_DATA, 1'b1);
                        CH_B: emit(CTL_BS, KIND_DATA, 1'b1);
                        CH_F: emit(CTL_FF, KIND_DATA, 1'b1);
                        CH_N: emit(CTL_LF, KIND_DATA, 1'b1);
                        CH_R: emit(CTL_CR, KIND_DATA, 1'b1);
                        CH_T: emit(CTL_TAB, KIND_DATA, 1'b1);
                        CH_U: begin
                            dec_phase = PH_HEX1;
                            dec_accum = 12'h000;
                        end
                        default: decode_fault();
                    endcase
                end
            end
            PH_HEX1, PH_HEX2, PH_HEX3: begin
                if (eot || !is_hex_digit(b)) begin
                    decode_fault();
                end else begin
                    dec_accum = {dec_accum[7:0], hex_nibble(b)};
                    case (dec_phase)
                        PH_HEX1: dec_phase = PH_HEX2;
                        PH_HEX2: dec_phase = PH_HEX3;
                        default: dec_phase = PH_HEX4;
                    endcase
                end
            end
            PH_HEX4: begin
                if (eot || !is_hex_digit(b)) begin
                    decode_fault();
                end else begin
                    cp        = {dec_accum, hex_nibble(b)};
                    dec_accum = 12'h000;
                    dec_phase = PH_STR;
                    if (cp < 16'h0080) begin
                        emit(cp[7:0], KIND_DATA, 1'b1);
                    end else if (cp < 16'h0800) begin
                        emit({3'b110, cp[10:6]}, KIND_DATA, 1'b0);
                        emit({2'b10, cp[5:0]}, KIND_DATA, 1'b1);
                    end else begin
                        n_wide++;
                        emit({4'b1110, cp[15:12]}, KIND_DATA, 1'b0);
                        emit({2'b10, cp[11:6]}, KIND_DATA, 1'b0);
                        emit({2'b10, cp[5:0]}, KIND_DATA, 1'b1);
                    end
                end
            end
            default: begin
                // waiting: only a quote that is not the last byte opens a string
                if (b != CH_QUOTE || eot) begin
                    decode_fault();
                end else begin
                    dec_phase = PH_STR;
                end
            end
        endcase
    endfunction

    // Idle length: mostly none, sometimes short, rarely long
    function automatic int gap_len();
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end else if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 30);
    endfunction

    function automatic void report_mismatch(input string msg);
        n_errors++;
        if (n_errors <= 40) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
    endfunction

    // Compare the transaction on the output with the oldest expected result
    function automatic void check_result();
        t_dec_result want;
        if (due_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result data=%02h kind=%0d last=%0b",
                                      m_tdata, m_tuser, m_tlast));
            return;
        end
        want = due_results.pop_front();
        case (want.kind)
            KIND_DATA: n_data++;
            KIND_DONE: n_done++;
            default:   n_fault++;
        endcase
        if (m_tdata !== want.data || m_tuser !== want.kind || m_tlast !== want.last) begin
            report_mismatch($sformatf("got data=%02h kind=%0d last=%0b, want %02h %0d %0b",
                                      m_tdata, m_tuser, m_tlast,
                                      want.data, want.kind, want.last));
        end
    endfunction

    // Offer one byte, hold it until accepted, then predict and maybe idle
    task automatic send_byte(input logic [7:0] b, input logic eot,
                             input logic typed = 1'b0, input logic [7:0] want_data = 8'h00,
                             input t_kind want_kind = KIND_DATA);
        t_dec_result r;
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        do begin
            @(posedge clk);
        end while (s_tready !== 1'b1);
        n_in++;
        decode_byte(b, eot);
        if (typed) begin
            r.data = want_data;
            r.kind = want_kind;
            r.last = 1'b1;
            due_results.push_back(r);
        end else begin
            foreach (step_out[k]) due_results.push_back(step_out[k]);
        end
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_code_point(input logic [15:0] cp, input int n_digits);
        for (int k = 3; k > 3 - n_digits; k--) begin
            send_byte(hex_char(cp[k*4 +: 4], 1'($urandom_range(0, 1))), 1'b0);
        end
    endtask

    // Break the string at this point in one of several ways
    task automatic send_broken_tail();
        logic [7:0] b;
        case ($urandom_range(0, 4))
            0: begin
                // raw byte as last of buffer
                do b = 8'($urandom); while (b == CH_QUOTE);
                send_byte(b, 1'b1);
            end
            1: begin
                // unknown escape letter
                send_byte(CH_BSLASH, 1'b0);
                do b = 8'($urandom);
                while (b == CH_QUOTE || b == CH_BSLASH || b == CH_SLASH || b == CH_B
                       || b == CH_F || b == CH_N || b == CH_R || b == CH_T || b == CH_U);
                send_byte(b, 1'($urandom_range(0, 1)));
            end
            2: begin
                // buffer ends on the byte right after the backslash
                send_byte(CH_BSLASH, 1'b0);
                send_byte(8'($urandom), 1'b1);
            end
            3: begin
                // non-hex byte at a random digit position
                send_byte(CH_BSLASH, 1'b0);
                send_byte(CH_U, 1'b0);
                send_code_point(16'($urandom), $urandom_range(0, 3));
                do b = 8'($urandom); while (is_hex_digit(b));
                send_byte(b, 1'b0);
            end
            default: begin
                // buffer ends on a hex digit
                send_byte(CH_BSLASH, 1'b0);
                send_byte(CH_U, 1'b0);
                send_code_point(16'($urandom), $urandom_range(0, 3));
                send_byte(hex_char(4'($urandom), 1'($urandom_range(0, 1))), 1'b1);
            end
        endcase
    endtask

    // One string literal with random content, sometimes broken on purpose
    task automatic send_string();
        int n_elem;
        int break_at;
        logic [7:0] b;
        logic [15:0] cp;
        n_elem   = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                               : $urandom_range(0, 8);
        break_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n_elem) : -1;
        send_byte(CH_QUOTE, 1'b0);
        for (int i = 0; i < n_elem; i++) begin
            if (i == break_at) begin
                send_broken_tail();
                return;
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    do b = 8'($urandom); while (b == CH_QUOTE || b == CH_BSLASH);
                    send_byte(b, 1'b0);
                end
                5, 6: begin
                    send_byte(CH_BSLASH, 1'b0);
                    case ($urandom_range(0, 7))
                        0:       b = CH_QUOTE;
                        1:       b = CH_BSLASH;
                        2:       b = CH_SLASH;
                        3:       b = CH_B;
                        4:       b = CH_F;
                        5:       b = CH_N;
                        6:       b = CH_R;
                        default: b = CH_T;
                    endcase
                    send_byte(b, 1'b0);
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0: cp = 16'($urandom_range(0, 16'h007F));
                        1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
                        2: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                        default: begin
                            case ($urandom_range(0, 5))
                                0:       cp = 16'h0000;
                                1:       cp = 16'h007F;
                                2:       cp = 16'h0080;
                                3:       cp = 16'h07FF;
                                4:       cp = 16'h0800;
                                default: cp = 16'hFFFF;
                            endcase
                        end
                    endcase
                    send_byte(CH_BSLASH, 1'b0);
                    send_byte(CH_U, 1'b0);
                    send_code_point(cp, 4);
                end
            endcase
        end
        if (break_at == n_elem) begin
            send_broken_tail();
        end else begin
            send_byte(CH_QUOTE, 1'($urandom_range(0, 3) == 0));
        end
    endtask

    // Stop all input and wait until every expected result has drained
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (due_results.size() != 0) @(posedge clk);
    endtask

    // Receiver: check each output transaction, stall at random, one long hold-off
    initial begin : rx_side
        int stall_left;
        int hold_left;
        bit hold_used;
        stall_left = 0;
        hold_left  = 0;
        hold_used  = 1'b0;
        forever begin
            @(posedge clk);
            if (m_tvalid === 1'b1 && m_tready) begin
                check_result();
            end
            if (hold_req && !hold_used) begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready   <= 1'b1;
                stall_left = gap_len();
            end
        end
    end

    // Watchdog: a run that never settles fails here
    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        bit drained;
        drained = 1'b0;
        dir_rows = '{
            '{8'h41,     1'b0, 1'b1, 8'h00,   KIND_ERR},   // text before any quote
            '{CH_QUOTE,  1'b1, 1'b1, 8'h00,   KIND_ERR},   // opening quote ends the buffer
            '{CH_QUOTE,  1'b0, 1'b0, 8'h00,   KIND_DATA},
            '{8'h00,     1'b0, 1'b1, 8'h00,   KIND_DATA},  // raw zero passes through
            '{8'hFF,     1'b0, 1'b1, 8'hFF,   KIND_DATA},  // raw high byte passes through
            '{CH_BSLASH, 1'b0, 1'b0, 8'h00,   KIND_DATA},
            '{CH_T,      1'b0, 1'b1, CTL_TAB, KIND_DATA},
            '{CH_BSLASH, 1'b0, 1'b0, 8'h00,   KIND_DATA},  // \u07Ff: top of two-byte range
            '{CH_U,      1'b0, 1'b0, 8'h00,   KIND_DATA},
            '{8'h30,     1'b0, 1'b0, 8'h00,   KIND_DATA},
            '{8'h37,     1'b0, 1'b0, 8'h00,   KIND_DATA},
            '{8'h46,     1'b0, 1'b0, 8'h00,   KIND_DATA},
            '{8'h66,     1'b0, 1'b0, 8'h00,   KIND_DATA},
            '{CH_BSLASH, 1'b0, 1'b0, 8'h00,   KIND_DATA},  // \uFfFf: largest code point
            '{CH_U,      1'b0, 1'b0, 8'h00,   KIND_DATA},
            '{8'h46,     1'b0, 1'b0, 8'h00,   KIND_DATA},
            '{8'h66,     1'b0, 1'b0, 8'h00,   KIND_DATA},
            '{8'h46,     1'b0, 1'b0, 8'h00,   KIND_DATA},
            '{8'h66,     1'b0, 1'b0, 8'h00,   KIND_DATA},
            '{CH_BSLASH, 1'b0, 1'b0, 8'h00,   KIND_DATA},
            '{8'h78,     1'b0, 1'b1, 8'h00,   KIND_ERR},   // unknown escape letter
            '{CH_QUOTE,  1'b0, 1'b0, 8'h00,   KIND_DATA},
            '{8'h41,     1'b1, 1'b1, 8'h00,   KIND_ERR},   // buffer ends inside the string
            '{CH_QUOTE,  1'b0, 1'b0, 8'h00,   KIND_DATA},
            '{CH_QUOTE,  1'b1, 1'b1, 8'h00,   KIND_DONE},  // closing quote on last byte
            '{CH_QUOTE,  1'b0, 1'b0, 8'h00,   KIND_DATA},
            '{CH_BSLASH, 1'b0, 1'b0, 8'h00,   KIND_DATA},
            '{CH_U,      1'b0, 1'b0, 8'h00,   KIND_DATA},
            '{8'h47,     1'b0, 1'b1, 8'h00,   KIND_ERR}    // non-hex digit
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            send_byte(dir_rows[i].data, dir_rows[i].eot, dir_rows[i].typed,
                      dir_rows[i].want_data, dir_rows[i].want_kind);
        end

        while (n_in - N_DIR < N_RAND) begin
            if (n_in - N_DIR >= 120) begin
                hold_req <= 1'b1;
            end
            quiet <= (n_in - N_DIR >= 300 && n_in - N_DIR < 360);
            if ($urandom_range(0, 7) == 0) begin
                // noise between strings: stray byte, or a quote that ends the buffer
                if ($urandom_range(0, 2) == 0) begin
                    send_byte(CH_QUOTE, 1'b1);
                end else begin
                    send_byte(8'($urandom_range(0, 255)) ^ (8'($urandom_range(0, 1)) << 1)
                              | 8'h01, 1'($urandom_range(0, 1)));
                end
            end
            send_string();
            if (!drained && n_in - N_DIR >= 240) begin
                drained = 1'b1;
                drain_results();
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d input bytes: directed edges, random strings, escapes and faults.",
                 n_in);
        $display("Checked %0d data bytes (%0d three-byte sequences), %0d completions, %0d errors.",
                 n_data, n_wide, n_done, n_fault);
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
